@@ hdl/mpwm_pkg.sv @@
`default_nettype none

package mpwm_pkg;

  localparam int NUM_CHANNELS = 8;
  localparam int PERIOD_STEPS = 255;

  localparam logic [7:0] LAST_STEP = 8'(PERIOD_STEPS - 1);

  localparam logic [15:0] CYCLE_COUNT_RESET = 16'd4;
  localparam logic [15:0] STEP_TICKS_RESET  = 16'd8;
  localparam logic        COUNT_DOWN_RESET  = 1'b1;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_WRITE = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    CFG_CYCLE_COUNT = 2'd0,
    CFG_STEP_TICKS  = 2'd1,
    CFG_COUNT_DOWN  = 2'd2
  } cfg_reg_t;

endpackage

`default_nettype wire

@@ hdl/multichannel_pwm_frame_update_unit.sv @@
`default_nettype none
// A tick item passes the input register and then the output register to the master side.
// Throughput: one item per cycle while the output is not stalled; duty write items produce no output item.
// While a finished item waits at the output, one more item is taken into the input
// register; a duty write there moves on, a tick there holds the input until the output frees.
// Reset (rst, synchronous): live duties, levels, queued writes, period and prescale counters
// cleared, step counter at 254, registers back to cycle_count 4, step_ticks 8, count_down 1.
module multichannel_pwm_frame_update_unit
  import mpwm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  // input items
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [2:0] channel, [10:3] duty, [15:11] zero
  input  wire logic        s_tuser,   // [0] opcode
  // result items
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [7:0] pin_levels, [15:8] step_index
  output logic             m_tuser    // [0] frame_start
);

  // configuration registers
  logic [15:0] cycle_count;
  logic [15:0] step_ticks;
  logic        count_down;

  // input register
  logic        in_vld;
  opcode_t     in_op;
  logic [2:0]  in_chan;
  logic [7:0]  in_duty;

  // state
  logic [7:0]  live_duty [NUM_CHANNELS];
  logic [7:0]  pending_duty [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] pending_valid;
  logic [7:0]  step_counter;
  logic [15:0] period_counter;
  logic [15:0] prescale_counter;
  logic [NUM_CHANNELS-1:0] level_register;

  // output register
  logic        out_vld;
  logic [7:0]  out_levels;
  logic [7:0]  out_step;
  logic        out_frame;

  logic        fire;
  logic        do_tick;
  logic        do_write;
  logic [7:0]  first_step;
  logic        at_first;
  logic        apply;
  logic [7:0]  live_duty_next [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] level_next;
  logic [15:0] ticks;
  logic [15:0] prescale_inc;
  logic        advance;
  logic [15:0] prescale_next;
  logic [7:0]  step_next;
  logic        wrapped;
  logic [15:0] period_inc;
  logic [15:0] period_next;

  assign cfg_ready = 1'b1;

  // a write item never blocks on the output side
  assign fire     = in_vld && (in_op == OP_WRITE || !out_vld || m_tready);
  assign do_tick  = fire && in_op == OP_TICK;
  assign do_write = fire && in_op == OP_WRITE;
  assign s_tready = !in_vld || fire;

  assign m_tvalid = out_vld;
  assign m_tdata  = {out_step, out_levels};
  assign m_tuser  = out_frame;

  always_comb begin
    first_step = count_down ? LAST_STEP : 8'd0;
    at_first   = period_counter == 16'd0 && prescale_counter == 16'd0 &&
                 step_counter == first_step;
    apply      = pending_valid != '0 && (cycle_count == 16'd0 || at_first);

    for (int c = 0; c < NUM_CHANNELS; c++) begin
      live_duty_next[c] = (apply && pending_valid[c]) ? pending_duty[c] : live_duty[c];
    end

    // hold levels in zero-count mode, but drop channels just given duty 0
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      if (cycle_count == 16'd0) begin
        level_next[c] = level_register[c] &&
                        !(apply && pending_valid[c] && pending_duty[c] == 8'd0);
      end else begin
        level_next[c] = live_duty_next[c] > step_counter;
      end
    end

    ticks         = (step_ticks == 16'd0) ? 16'd1 : step_ticks;
    prescale_inc  = prescale_counter + 16'd1;
    advance       = prescale_inc >= ticks;
    prescale_next = advance ? 16'd0 : prescale_inc;

    wrapped   = 1'b0;
    step_next = step_counter;
    if (advance) begin
      if (count_down) begin
        if (step_counter == 8'd0 || step_counter > LAST_STEP) begin
          step_next = LAST_STEP;
          wrapped   = 1'b1;
        end else begin
          step_next = step_counter - 8'd1;
        end
      end else begin
        if (step_counter >= LAST_STEP) begin
          step_next = 8'd0;
          wrapped   = 1'b1;
        end else begin
          step_next = step_counter + 8'd1;
        end
      end
    end

    period_inc  = period_counter + 16'd1;
    period_next = period_counter;
    if (wrapped) begin
      period_next = (period_inc >= cycle_count) ? 16'd0 : period_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cycle_count <= CYCLE_COUNT_RESET;
      step_ticks  <= STEP_TICKS_RESET;
      count_down  <= COUNT_DOWN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_CYCLE_COUNT: cycle_count <= cfg_data;
        CFG_STEP_TICKS:  step_ticks  <= cfg_data;
        CFG_COUNT_DOWN:  count_down  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op   <= opcode_t'(s_tuser);
      in_chan <= s_tdata[2:0];
      in_duty <= s_tdata[10:3];
    end
  end

  // queued duties: payload only, valid bits below
  always_ff @(posedge clk) begin
    if (do_write && 32'(in_chan) < NUM_CHANNELS) begin
      pending_duty[in_chan] <= in_duty;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_valid    <= '0;
      level_register   <= '0;
      step_counter     <= LAST_STEP;
      period_counter   <= 16'd0;
      prescale_counter <= 16'd0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        live_duty[c] <= 8'd0;
      end
    end else if (do_write) begin
      if (32'(in_chan) < NUM_CHANNELS) begin
        pending_valid[in_chan] <= 1'b1;
      end
    end else if (do_tick) begin
      if (apply) begin
        pending_valid <= '0;
      end
      live_duty      <= live_duty_next;
      level_register <= level_next;
      // counters freeze while cycle_count is zero
      if (cycle_count != 16'd0) begin
        step_counter     <= step_next;
        period_counter   <= period_next;
        prescale_counter <= prescale_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (do_tick) begin
      out_vld <= 1'b1;
    end else if (m_tready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_tick) begin
      out_levels <= level_next;
      out_step   <= step_counter;
      out_frame  <= apply;
    end
  end

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import mpwm_pkg::*;

  typedef struct packed {
    logic [7:0] levels;
    logic       frame;
    logic [7:0] step;
  } pwm_result_t;

  typedef struct packed {
    bit          is_cfg;
    cfg_reg_t    reg_sel;
    logic [15:0] value;
    opcode_t     op;
    logic [2:0]  ch;
    logic [7:0]  duty;
    bit          typed;
    pwm_result_t want;
  } dir_row_t;

  typedef struct {
    logic [15:0] cycles;
    logic [15:0] ticks;
    logic        down;
    int          n_items;
    bit          hold;
  } phase_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tuser;

  multichannel_pwm_frame_update_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state
  logic [7:0]  live_duty [NUM_CHANNELS];
  logic [7:0]  queued_duty [NUM_CHANNELS];
  logic [7:0]  queued_mask = '0;
  logic [7:0]  pin_state = '0;
  logic [7:0]  step_cnt = LAST_STEP;
  logic [15:0] period_cnt = '0;
  logic [15:0] prescale_cnt = '0;
  logic [15:0] cycles_cfg = CYCLE_COUNT_RESET;
  logic [15:0] ticks_cfg = STEP_TICKS_RESET;
  logic        down_cfg = COUNT_DOWN_RESET;

  pwm_result_t pwm_expected [$];

  int errors = 0;
  int n_ticks = 0;
  int n_writes = 0;
  int n_checked = 0;
  int n_frames = 0;
  int src_gap_pct = 0;
  int snk_stall_pct = 0;
  bit long_hold_req = 1'b0;

  initial begin
    #7_200_000;
    $display("== FAIL ==");
    $display("timeout at %0t with %0d results outstanding", $time, pwm_expected.size());
    $finish;
  end

  initial begin
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      live_duty[c] = '0;
      queued_duty[c] = '0;
    end
  end

  function automatic bit apply_queued();
    int c;
    if (queued_mask == '0) return 1'b0;
    for (c = 0; c < NUM_CHANNELS; c++) begin
      if (queued_mask[c]) begin
        live_duty[c] = queued_duty[c];
        if (queued_duty[c] == 8'd0) pin_state[c] = 1'b0;
      end
    end
    queued_mask = '0;
    return 1'b1;
  endfunction

  // Returns 1 when the item yields a result item.
  function automatic bit pwm_predict(input opcode_t op, input logic [2:0] ch,
                                     input logic [7:0] duty, output pwm_result_t res);
    logic [7:0]  first_step;
    logic [7:0]  step_now;
    logic [15:0] ticks;
    bit          applied;
    bit          wrapped;
    int          c;
    applied = 1'b0;
    wrapped = 1'b0;
    res = '0;
    if (op == OP_WRITE) begin
      queued_duty[ch] = duty;
      queued_mask[ch] = 1'b1;
      return 1'b0;
    end
    first_step = down_cfg ? LAST_STEP : 8'd0;
    if (cycles_cfg == 16'd0) begin
      // zero cycle count: apply every tick, counters hold, levels hold but for channels just given duty 0
      applied = apply_queued();
      step_now = step_cnt;
    end else begin
      if (period_cnt == 16'd0 && prescale_cnt == 16'd0 && step_cnt == first_step)
        applied = apply_queued();
      step_now = step_cnt;
      for (c = 0; c < NUM_CHANNELS; c++) pin_state[c] = (live_duty[c] > step_now);
      ticks = (ticks_cfg == 16'd0) ? 16'd1 : ticks_cfg;
      prescale_cnt = prescale_cnt + 16'd1;
      if (prescale_cnt >= ticks) begin
        prescale_cnt = '0;
        if (down_cfg) begin
          if (step_cnt == 8'd0 || step_cnt > LAST_STEP) begin
            step_cnt = LAST_STEP;
            wrapped = 1'b1;
          end else begin
            step_cnt = step_cnt - 8'd1;
          end
        end else begin
          if (step_cnt >= LAST_STEP) begin
            step_cnt = 8'd0;
            wrapped = 1'b1;
          end else begin
            step_cnt = step_cnt + 8'd1;
          end
        end
        if (wrapped) begin
          period_cnt = period_cnt + 16'd1;
          if (period_cnt >= cycles_cfg) period_cnt = '0;
        end
      end
    end
    res.levels = pin_state;
    res.frame = applied;
    res.step = step_now;
    return 1'b1;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic dir_row_t tick_row(bit typed, logic [7:0] lv, logic fs, logic [7:0] st);
    dir_row_t r;
    r = '0;
    r.op = OP_TICK;
    r.typed = typed;
    r.want = '{levels: lv, frame: fs, step: st};
    return r;
  endfunction

  function automatic dir_row_t write_row(logic [2:0] ch, logic [7:0] duty);
    dir_row_t r;
    r = '0;
    r.op = OP_WRITE;
    r.ch = ch;
    r.duty = duty;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(cfg_reg_t sel, logic [15:0] value);
    dir_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.reg_sel = sel;
    r.value = value;
    return r;
  endfunction

  task automatic put_item(opcode_t op, logic [2:0] ch, logic [7:0] duty, bit typed,
                          pwm_result_t want);
    pwm_result_t res;
    int gap;
    gap = ($urandom_range(0, 99) < src_gap_pct) ? gap_len() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {5'd0, duty, ch};
    do @(posedge clk); while (!s_tready);
    if (op == OP_TICK) n_ticks++;
    else n_writes++;
    if (pwm_predict(op, ch, duty, res)) begin
      if (typed) res = want;
      pwm_expected.push_back(res);
    end
  endtask

  // Hold the input, let every result come out and writes settle in the pipeline.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pwm_expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t sel, logic [15:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (sel)
      CFG_CYCLE_COUNT: cycles_cfg = value;
      CFG_STEP_TICKS:  ticks_cfg = value;
      CFG_COUNT_DOWN:  down_cfg = value[0];
      default: ;
    endcase
  endtask

  task automatic check_result(pwm_result_t got);
    pwm_result_t want;
    if (pwm_expected.size() == 0) begin
      $display("%0t: result with nothing expected: levels %h frame %b step %0d",
               $time, got.levels, got.frame, got.step);
      errors++;
    end else begin
      want = pwm_expected.pop_front();
      n_checked++;
      if (got.frame) n_frames++;
      if (got.levels !== want.levels) begin
        $display("%0t: pin_levels expected %h actual %h", $time, want.levels, got.levels);
        errors++;
      end
      if (got.frame !== want.frame) begin
        $display("%0t: frame_start expected %b actual %b", $time, want.frame, got.frame);
        errors++;
      end
      if (got.step !== want.step) begin
        $display("%0t: step_index expected %0d actual %0d", $time, want.step, got.step);
        errors++;
      end
    end
  endtask

  // Result side: random stalls plus an occasional long hold-off.
  initial begin : result_sink
    int stall;
    stall = 0;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready)
        check_result('{levels: m_tdata[7:0], frame: m_tuser, step: m_tdata[15:8]});
      if (stall > 0) begin
        stall--;
      end else if (long_hold_req) begin
        stall = 200;
        long_hold_req = 1'b0;
      end else if ($urandom_range(0, 99) < snk_stall_pct) begin
        stall = gap_len();
      end
      m_tready <= (stall == 0);
    end
  end

  initial begin : stimulus
    dir_row_t    dir_rows [24];
    phase_t      phases [6];
    pwm_result_t none;
    opcode_t     op;
    logic [7:0]  duty;
    int          pick;
    none = '0;
    dir_rows = '{
      tick_row(1, 8'h00, 1'b0, 8'd254),
      write_row(3'd0, 8'd255),
      write_row(3'd7, 8'd255),
      write_row(3'd3, 8'd0),
      write_row(3'd3, 8'd128),
      tick_row(1, 8'h00, 1'b0, 8'd254),
      cfg_row(CFG_CYCLE_COUNT, 16'd0),
      tick_row(1, 8'h00, 1'b1, 8'd254),
      write_row(3'd0, 8'd0),
      tick_row(1, 8'h00, 1'b1, 8'd254),
      tick_row(1, 8'h00, 1'b0, 8'd254),
      cfg_row(CFG_STEP_TICKS, 16'd0),
      cfg_row(CFG_CYCLE_COUNT, 16'd1),
      tick_row(0, '0, 1'b0, '0),
      tick_row(0, '0, 1'b0, '0),
      cfg_row(CFG_COUNT_DOWN, 16'd0),
      tick_row(0, '0, 1'b0, '0),
      write_row(3'd1, 8'd1),
      write_row(3'd2, 8'd254),
      tick_row(0, '0, 1'b0, '0),
      cfg_row(CFG_CYCLE_COUNT, 16'd65535),
      cfg_row(CFG_STEP_TICKS, 16'd65535),
      write_row(3'd6, 8'hAA),
      tick_row(0, '0, 1'b0, '0)
    };
    // step_ticks drops from 65535 to a small value mid-count in the phase after it
    phases = '{
      '{16'd1,     16'd1,     1'b0, 400, 1'b1},
      '{16'd0,     16'd3,     1'b1, 100, 1'b0},
      '{16'd65535, 16'd65535, 1'b1, 50,  1'b0},
      '{16'd1,     16'd0,     1'b1, 250, 1'b0},
      '{16'd2,     16'd2,     1'b0, 100, 1'b1},
      '{16'd0,     16'd1,     1'b0, 50,  1'b0}
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg)
        write_reg(dir_rows[i].reg_sel, dir_rows[i].value);
      else
        put_item(dir_rows[i].op, dir_rows[i].ch, dir_rows[i].duty, dir_rows[i].typed,
                 dir_rows[i].want);
    end

    foreach (phases[p]) begin
      write_reg(CFG_CYCLE_COUNT, phases[p].cycles);
      write_reg(CFG_STEP_TICKS, phases[p].ticks);
      write_reg(CFG_COUNT_DOWN, {15'd0, phases[p].down});
      src_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 30;
      snk_stall_pct = ($urandom_range(0, 2) == 0) ? 0 : 25;
      if (phases[p].hold) long_hold_req = 1'b1;
      repeat (phases[p].n_items) begin
        op = ($urandom_range(0, 99) < 80) ? OP_TICK : OP_WRITE;
        pick = $urandom_range(0, 9);
        if (pick == 0) duty = 8'd0;
        else if (pick == 1) duty = 8'd255;
        else duty = 8'($urandom_range(0, 255));
        put_item(op, 3'($urandom_range(0, 7)), duty, 1'b0, none);
      end
    end

    s_tvalid <= 1'b0;
    while (pwm_expected.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Ran %0d tick and %0d duty write items; %0d results checked, %0d frame starts",
             n_ticks, n_writes, n_checked, n_frames);
    $display("Settings: cycle_count 0..65535, step_ticks 0..65535, both count directions");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
